[hw/rtl/lwl_pkg.sv]
// ----------------------------------------------------------------------------
// lwl_pkg
// Shared types and constants for the layered window list engine.
// ----------------------------------------------------------------------------
package lwl_pkg;

  localparam int unsigned LIST_DEPTH_DEF  = 64;
  localparam int unsigned HANDLE_BITS_DEF = 8;

  // Attribute bit positions
  localparam int unsigned ATTR_VISIBLE = 0;
  localparam int unsigned ATTR_CURSOR  = 1;
  localparam int unsigned ATTR_ARBITER = 2;
  localparam int unsigned ATTR_FRAGILE = 3;

  typedef enum logic [2:0] {
    KIND_INSERT = 3'd0,
    KIND_RAISE  = 3'd1,
    KIND_REMOVE = 3'd2,
    KIND_FIND   = 3'd3,
    KIND_SELECT = 3'd4,
    KIND_HIDE   = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_DONE     = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_NOTFOUND = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SHIFT_RD,
    ST_SHIFT_CHK,
    ST_PUT,
    ST_DONE
  } state_e;

endpackage

[hw/rtl/layered_window_list_engine_unit.sv]
// ----------------------------------------------------------------------------
// layered_window_list_engine_unit
// Operation: each entry that an item visits is read from the entry memory in
//   a read state and then tested or moved in a check state. One item is
//   worked at a time; the next is taken once the result sits in the output
//   register. Reset clears the state, entry count, active handle and output
//   valid only; the entry memory is not cleared.
// ----------------------------------------------------------------------------
module layered_window_list_engine_unit #(
  parameter int unsigned LIST_DEPTH  = lwl_pkg::LIST_DEPTH_DEF,
  parameter int unsigned HANDLE_BITS = lwl_pkg::HANDLE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic [7:0]  handle_i,
  input  logic [15:0] pos_x_i,
  input  logic [15:0] pos_y_i,
  input  logic [15:0] size_w_i,
  input  logic [15:0] size_h_i,
  input  logic [3:0]  attr_i,
  input  logic [15:0] point_x_i,
  input  logic [15:0] point_y_i,
  input  logic        include_hidden_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [7:0]  result_handle_o,
  output logic [6:0]  list_count_o
);
  import lwl_pkg::*;

  localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  typedef struct packed {
    logic [HANDLE_BITS-1:0] hnd;
    logic [15:0]            left;
    logic [15:0]            top;
    logic [15:0]            wid;
    logic [15:0]            hgt;
    logic [3:0]             attr;
  } entry_t;

  state_e                 state_q, state_d;
  logic [CW-1:0]          idx_q, idx_d, pos_q, pos_d, total_q, total_d;
  logic [HANDLE_BITS-1:0] active_q, active_d, res_q, res_d;
  status_e                status_q, status_d;
  entry_t                 hold_q, hold_d, nent_q, nent_d;
  kind_e                  kind_q, kind_d;
  logic [15:0]            px_q, px_d, py_q, py_d;
  logic                   hid_q, hid_d;
  logic                   ovalid_q, ovalid_d;
  logic [1:0]             ostatus_q, ostatus_d;
  logic [7:0]             ores_q, ores_d;
  logic [6:0]             ocount_q, ocount_d;

  entry_t                 mem [LIST_DEPTH];
  entry_t                 rdata_q, wdata;
  logic                   mem_we;
  logic [AW-1:0]          raddr, waddr;

  logic                   in_acc, out_free, scan_end, shift_end, shift_up;
  logic                   blocker, scan_stop, hit;
  logic [15:0]            hnd_wide, res_wide, cnt_wide;
  logic signed [17:0]     ex_l, ex_t, ex_px, ex_py, ex_r, ex_b;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign out_free   = ~ovalid_q | ~out_stall_i;

  assign out_valid_o     = ovalid_q;
  assign status_o        = ostatus_q;
  assign result_handle_o = ores_q;
  assign list_count_o    = ocount_q;

  assign hnd_wide = 16'(handle_i);

  // Entry tests on the word read back from memory
  assign blocker = rdata_q.attr[ATTR_ARBITER] | rdata_q.attr[ATTR_CURSOR];
  assign ex_l    = 18'(signed'(rdata_q.left));
  assign ex_t    = 18'(signed'(rdata_q.top));
  assign ex_px   = signed'({2'b00, px_q});
  assign ex_py   = signed'({2'b00, py_q});
  assign ex_r    = ex_l + signed'({2'b00, rdata_q.wid});
  assign ex_b    = ex_t + signed'({2'b00, rdata_q.hgt});
  assign hit     = (hid_q | rdata_q.attr[ATTR_VISIBLE]) & ~rdata_q.attr[ATTR_CURSOR] &
                   (ex_l <= ex_px) & (ex_t <= ex_py) & (ex_px < ex_r) & (ex_py < ex_b);

  always_comb begin
    unique case (kind_q)
      KIND_INSERT: scan_stop = blocker;
      KIND_RAISE:  scan_stop = (rdata_q.hnd == hold_q.hnd);
      KIND_REMOVE: scan_stop = (rdata_q.hnd == hold_q.hnd);
      KIND_FIND:   scan_stop = hit;
      KIND_SELECT: scan_stop = rdata_q.attr[ATTR_ARBITER];
      default:     scan_stop = 1'b0;
    endcase
  end

  assign scan_end  = (kind_q == KIND_FIND) ? (idx_q == '0) : (idx_q == total_q);
  assign shift_up  = (kind_q != KIND_INSERT);
  assign shift_end = shift_up ? ((idx_q + ONE_C) == total_q) : (idx_q == pos_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          priority if (kind_e'(kind_i) == KIND_INSERT) begin
            if (total_q == DEPTH_C) state_d = ST_DONE;
            else if (attr_i[ATTR_CURSOR]) state_d = ST_SHIFT_RD;
            else state_d = ST_SCAN_RD;
          end else if (kind_i <= 3'(KIND_HIDE)) begin
            state_d = ST_SCAN_RD;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SCAN_RD: begin
        if (!scan_end) state_d = ST_SCAN_CHK;
        else if (kind_q == KIND_INSERT) state_d = ST_SHIFT_RD;
        else state_d = ST_DONE;
      end
      ST_SCAN_CHK: begin
        if (!scan_stop) state_d = ST_SCAN_RD;
        else if (kind_q == KIND_FIND || kind_q == KIND_SELECT) state_d = ST_DONE;
        else state_d = ST_SHIFT_RD;
      end
      ST_SHIFT_RD: begin
        if (!shift_end) state_d = ST_SHIFT_CHK;
        else if (kind_q == KIND_REMOVE) state_d = ST_DONE;
        else state_d = ST_PUT;
      end
      ST_SHIFT_CHK: begin
        if (kind_q == KIND_RAISE && blocker) state_d = ST_PUT;
        else state_d = ST_SHIFT_RD;
      end
      ST_PUT:  state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    idx_d     = idx_q;
    pos_d     = pos_q;
    total_d   = total_q;
    active_d  = active_q;
    res_d     = res_q;
    status_d  = status_q;
    hold_d    = hold_q;
    nent_d    = nent_q;
    kind_d    = kind_q;
    px_d      = px_q;
    py_d      = py_q;
    hid_d     = hid_q;
    ovalid_d  = ovalid_q & out_stall_i;
    ostatus_d = ostatus_q;
    ores_d    = ores_q;
    ocount_d  = ocount_q;
    mem_we    = 1'b0;
    waddr     = idx_q[AW-1:0];
    wdata     = rdata_q;
    raddr     = idx_q[AW-1:0];
    res_wide  = '0;
    cnt_wide  = 16'(total_q);

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          // latch the operation
          kind_d      = kind_e'(kind_i);
          nent_d.hnd  = hnd_wide[HANDLE_BITS-1:0];
          nent_d.left = pos_x_i;
          nent_d.top  = pos_y_i;
          nent_d.wid  = size_w_i;
          nent_d.hgt  = size_h_i;
          nent_d.attr = attr_i;
          hold_d      = '0;
          hold_d.hnd  = hnd_wide[HANDLE_BITS-1:0];
          px_d        = point_x_i;
          py_d        = point_y_i;
          hid_d       = include_hidden_i;
          res_d       = '0;
          status_d    = STATUS_DONE;
          pos_d       = total_q;
          idx_d       = (kind_e'(kind_i) == KIND_FIND ||
                         (kind_e'(kind_i) == KIND_INSERT && attr_i[ATTR_CURSOR])) ?
                        total_q : '0;
          if (kind_e'(kind_i) == KIND_INSERT && total_q == DEPTH_C) status_d = STATUS_FULL;
        end
      end
      ST_SCAN_RD: begin
        raddr = (kind_q == KIND_FIND) ? AW'(idx_q - ONE_C) : idx_q[AW-1:0];
        if (scan_end) begin
          if (kind_q == KIND_INSERT) begin
            pos_d = total_q;
            idx_d = total_q;
          end else if (kind_q == KIND_RAISE || kind_q == KIND_REMOVE ||
                       kind_q == KIND_FIND) begin
            status_d = STATUS_NOTFOUND;
          end
        end
      end
      ST_SCAN_CHK: begin
        if (scan_stop) begin
          if (kind_q == KIND_INSERT) begin
            pos_d = idx_q;
            idx_d = total_q;
          end else if (kind_q == KIND_RAISE) begin
            hold_d = rdata_q;
          end else if (kind_q == KIND_FIND) begin
            res_d = rdata_q.hnd;
          end
        end else begin
          // advance the walk
          idx_d = (kind_q == KIND_FIND) ? idx_q - ONE_C : idx_q + ONE_C;
          if (kind_q == KIND_SELECT && rdata_q.attr[ATTR_VISIBLE]) active_d = rdata_q.hnd;
          if (kind_q == KIND_HIDE && rdata_q.attr[ATTR_FRAGILE]) begin
            mem_we = 1'b1;
            wdata.attr[ATTR_VISIBLE] = 1'b0;
          end
        end
      end
      ST_SHIFT_RD: begin
        raddr = shift_up ? AW'(idx_q + ONE_C) : AW'(idx_q - ONE_C);
        if (shift_end && kind_q == KIND_REMOVE) total_d = total_q - ONE_C;
      end
      ST_SHIFT_CHK: begin
        if (!(kind_q == KIND_RAISE && blocker)) begin
          mem_we = 1'b1;
          idx_d  = shift_up ? idx_q + ONE_C : idx_q - ONE_C;
        end
      end
      ST_PUT: begin
        mem_we = 1'b1;
        if (kind_q == KIND_INSERT) begin
          wdata   = nent_q;
          total_d = total_q + ONE_C;
        end else begin
          wdata = hold_q;
        end
      end
      ST_DONE: begin
        res_wide = 16'((kind_q == KIND_SELECT) ? active_q : res_q);
        if (out_free) begin
          ovalid_d  = 1'b1;
          ostatus_d = status_q;
          ores_d    = res_wide[7:0];
          ocount_d  = cnt_wide[6:0];
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      total_q  <= '0;
      active_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      total_q  <= total_d;
      active_q <= active_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    pos_q     <= pos_d;
    res_q     <= res_d;
    status_q  <= status_d;
    hold_q    <= hold_d;
    nent_q    <= nent_d;
    kind_q    <= kind_d;
    px_q      <= px_d;
    py_q      <= py_d;
    hid_q     <= hid_d;
    ostatus_q <= ostatus_d;
    ores_q    <= ores_d;
    ocount_q  <= ocount_d;
  end

  // Entry memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

endmodule

[hw/rtl/lwl_checker.sv]
// ----------------------------------------------------------------------------
// lwl_checker
// Port-level checks on the layered window list engine.
// ----------------------------------------------------------------------------
module lwl_checker #(
  parameter int unsigned LIST_DEPTH = lwl_pkg::LIST_DEPTH_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] status_o,
  input logic [7:0] result_handle_o,
  input logic [6:0] list_count_o
);
  import lwl_pkg::*;

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(result_handle_o) && $stable(list_count_o))
    else $error("stalled result changed");

  // one item in flight: stall after each transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(list_count_o) <= LIST_DEPTH && status_o != 2'd3)
    else $error("count or status out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_FULL |-> 32'(list_count_o) == LIST_DEPTH)
    else $error("full reported below depth");

endmodule

bind layered_window_list_engine_unit lwl_checker #(.LIST_DEPTH(LIST_DEPTH)) u_lwl_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .status_o        (status_o),
  .result_handle_o (result_handle_o),
  .list_count_o    (list_count_o)
);

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the layered window list engine: a directed table of
// operations followed by random traffic, each result compared against a local
// model of the window list under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
  import lwl_pkg::*;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned N_RANDOM = 1450;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  handle;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] size_w;
    logic [15:0] size_h;
    logic [3:0]  attr;
    logic [15:0] point_x;
    logic [15:0] point_y;
    logic        include_hidden;
  } op_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] result_handle;
    logic [6:0] list_count;
  } res_t;

  typedef struct {
    op_t  op;
    logic typed;
    res_t res;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  kind_i = '0;
  logic [7:0]  handle_i = '0;
  logic [15:0] pos_x_i = '0;
  logic [15:0] pos_y_i = '0;
  logic [15:0] size_w_i = '0;
  logic [15:0] size_h_i = '0;
  logic [3:0]  attr_i = '0;
  logic [15:0] point_x_i = '0;
  logic [15:0] point_y_i = '0;
  logic        include_hidden_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [7:0]  result_handle_o;
  logic [6:0]  list_count_o;

  layered_window_list_engine_unit dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Model of the window list
  logic [7:0]  w_handle [DEPTH];
  logic [15:0] w_left   [DEPTH];
  logic [15:0] w_top    [DEPTH];
  logic [15:0] w_width  [DEPTH];
  logic [15:0] w_height [DEPTH];
  logic [3:0]  w_attr   [DEPTH];
  int          w_total;
  logic [7:0]  w_active;

  res_t pending_results[$];
  int   fail_count;
  logic hold_off;

  function automatic int find_lowest(logic [7:0] h);
    for (int i = 0; i < w_total; i++) if (w_handle[i] == h) return i;
    return -1;
  endfunction

  function automatic void move_entry(int dst, int src);
    w_handle[dst] = w_handle[src];
    w_left[dst]   = w_left[src];
    w_top[dst]    = w_top[src];
    w_width[dst]  = w_width[src];
    w_height[dst] = w_height[src];
    w_attr[dst]   = w_attr[src];
  endfunction

  function automatic res_t apply_window_op(op_t op);
    res_t r;
    int at;
    int l, t, px, py;
    logic [7:0]  sh;
    logic [15:0] sl, st, sw, sht;
    logic [3:0]  sa;
    r = '0;
    case (op.kind)
      KIND_INSERT: begin
        if (w_total >= DEPTH) r.status = STATUS_FULL;
        else begin
          at = w_total;
          if (!op.attr[ATTR_CURSOR])
            for (int i = 0; i < w_total; i++)
              if (w_attr[i][ATTR_ARBITER] || w_attr[i][ATTR_CURSOR]) begin
                at = i;
                break;
              end
          for (int i = w_total; i > at; i--) move_entry(i, i - 1);
          w_handle[at] = op.handle;
          w_left[at]   = op.pos_x;
          w_top[at]    = op.pos_y;
          w_width[at]  = op.size_w;
          w_height[at] = op.size_h;
          w_attr[at]   = op.attr;
          w_total++;
        end
      end
      KIND_RAISE: begin
        at = find_lowest(op.handle);
        if (at < 0) r.status = STATUS_NOTFOUND;
        else begin
          sh = w_handle[at]; sl = w_left[at]; st = w_top[at];
          sw = w_width[at]; sht = w_height[at]; sa = w_attr[at];
          while (at + 1 < w_total &&
                 !(w_attr[at+1][ATTR_ARBITER] || w_attr[at+1][ATTR_CURSOR])) begin
            move_entry(at, at + 1);
            at++;
          end
          w_handle[at] = sh; w_left[at] = sl; w_top[at] = st;
          w_width[at] = sw; w_height[at] = sht; w_attr[at] = sa;
        end
      end
      KIND_REMOVE: begin
        at = find_lowest(op.handle);
        if (at < 0) r.status = STATUS_NOTFOUND;
        else begin
          for (int i = at; i + 1 < w_total; i++) move_entry(i, i + 1);
          w_total--;
        end
      end
      KIND_FIND: begin
        px = op.point_x;
        py = op.point_y;
        r.status = STATUS_NOTFOUND;
        for (int k = w_total - 1; k >= 0; k--) begin
          l = $signed(w_left[k]);
          t = $signed(w_top[k]);
          if (!op.include_hidden && !w_attr[k][ATTR_VISIBLE]) continue;
          if (l > px || t > py) continue;
          if (l + int'(w_width[k]) <= px) continue;
          if (t + int'(w_height[k]) <= py) continue;
          if (w_attr[k][ATTR_CURSOR]) continue;
          r.status = STATUS_DONE;
          r.result_handle = w_handle[k];
          break;
        end
      end
      KIND_SELECT: begin
        for (int i = 0; i < w_total; i++) begin
          if (w_attr[i][ATTR_ARBITER]) break;
          if (w_attr[i][ATTR_VISIBLE]) w_active = w_handle[i];
        end
        r.result_handle = w_active;
      end
      KIND_HIDE: begin
        for (int i = 0; i < w_total; i++)
          if (w_attr[i][ATTR_FRAGILE]) w_attr[i][ATTR_VISIBLE] = 1'b0;
      end
      default: ;
    endcase
    r.list_count = w_total[6:0];
    return r;
  endfunction

  function automatic op_t blank_op(logic [2:0] kind);
    op_t op;
    op = '0;
    op.kind = kind;
    return op;
  endfunction

  function automatic op_t insert_op(logic [7:0] h, logic [15:0] x, logic [15:0] y,
                                    logic [15:0] w, logic [15:0] hh, logic [3:0] a);
    op_t op;
    op = blank_op(KIND_INSERT);
    op.handle = h; op.pos_x = x; op.pos_y = y;
    op.size_w = w; op.size_h = hh; op.attr = a;
    return op;
  endfunction

  function automatic op_t find_op(logic [15:0] x, logic [15:0] y, logic hid);
    op_t op;
    op = blank_op(KIND_FIND);
    op.point_x = x; op.point_y = y; op.include_hidden = hid;
    return op;
  endfunction

  function automatic op_t handle_op(logic [2:0] kind, logic [7:0] h);
    op_t op;
    op = blank_op(kind);
    op.handle = h;
    return op;
  endfunction

  // Random item, biased towards a small handle pool so raise/remove hit
  function automatic op_t random_op();
    op_t op;
    int sel;
    op = op_t'(112'({$urandom, $urandom, $urandom, $urandom}));
    sel = $urandom_range(0, 99);
    if (sel < 40) op.kind = KIND_INSERT;
    else if (sel < 52) op.kind = KIND_RAISE;
    else if (sel < 72) op.kind = KIND_REMOVE;
    else if (sel < 88) op.kind = KIND_FIND;
    else if (sel < 93) op.kind = KIND_SELECT;
    else if (sel < 97) op.kind = KIND_HIDE;
    else op.kind = 3'($urandom_range(6, 7));
    if ($urandom_range(0, 9) < 8) op.handle = 8'($urandom_range(0, 15));
    if ($urandom_range(0, 3) != 0) begin
      op.pos_x = 16'($urandom_range(0, 200));
      op.pos_y = 16'($urandom_range(0, 200));
      op.size_w = 16'($urandom_range(0, 150));
      op.size_h = 16'($urandom_range(0, 150));
      op.point_x = 16'($urandom_range(0, 300));
      op.point_y = 16'($urandom_range(0, 300));
    end
    return op;
  endfunction

  // Present one item and hold it until the transfer
  task automatic send_op(op_t op);
    res_t r;
    in_valid_i <= 1'b1;
    kind_i <= op.kind; handle_i <= op.handle;
    pos_x_i <= op.pos_x; pos_y_i <= op.pos_y;
    size_w_i <= op.size_w; size_h_i <= op.size_h;
    attr_i <= op.attr; point_x_i <= op.point_x; point_y_i <= op.point_y;
    include_hidden_i <= op.include_hidden;
    do @(posedge clk_i); while (in_stall_o);
    r = apply_window_op(op);
    pending_results.push_back(r);
  endtask

  task automatic idle_sender(int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Receiver: stall pattern plus a long hold-off when asked
  initial begin
    int mode;
    mode = 0;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 199) == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: out_stall_i <= hold_off;
        1: out_stall_i <= hold_off || ($urandom_range(0, 3) == 0);
        default: out_stall_i <= hold_off || ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    res_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d handle %0d count %0d",
               status_o, result_handle_o, list_count_o);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (status_o !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, status_o);
          fail_count++;
        end
        if (result_handle_o !== exp_r.result_handle) begin
          $error("result_handle: expected %0d, actual %0d",
                 exp_r.result_handle, result_handle_o);
          fail_count++;
        end
        if (list_count_o !== exp_r.list_count) begin
          $error("list_count: expected %0d, actual %0d",
                 exp_r.list_count, list_count_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("[layered_window_list_engine_unit] ERROR");
    $finish;
  end

  initial begin
    row_t table_rows[$];
    row_t row;
    op_t op;
    int burst;
    res_t dummy;
    fail_count = 0;
    hold_off = 1'b0;
    w_total = 0;
    w_active = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table; typed results where obvious
    table_rows.push_back('{blank_op(KIND_FIND), 1'b1, res_t'({STATUS_NOTFOUND, 8'd0, 7'd0})});
    table_rows.push_back('{handle_op(KIND_RAISE, 8'd3), 1'b1,
                           res_t'({STATUS_NOTFOUND, 8'd0, 7'd0})});
    table_rows.push_back('{handle_op(KIND_REMOVE, 8'd3), 1'b1,
                           res_t'({STATUS_NOTFOUND, 8'd0, 7'd0})});
    table_rows.push_back('{blank_op(KIND_SELECT), 1'b1, res_t'({STATUS_DONE, 8'd0, 7'd0})});
    table_rows.push_back('{blank_op(KIND_HIDE), 1'b1, res_t'({STATUS_DONE, 8'd0, 7'd0})});
    table_rows.push_back('{blank_op(3'd6), 1'b1, res_t'({STATUS_DONE, 8'd0, 7'd0})});
    table_rows.push_back('{blank_op(3'd7), 1'b1, res_t'({STATUS_DONE, 8'd0, 7'd0})});
    table_rows.push_back('{insert_op(8'hFF, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 4'b1001),
                           1'b1, res_t'({STATUS_DONE, 8'd0, 7'd1})});
    table_rows.push_back('{insert_op(8'h00, 16'h7FFF, 16'h7FFF, 16'h0001, 16'h0001, 4'b0001),
                           1'b0, res_t'('0)});
    table_rows.push_back('{insert_op(8'h22, 16'd0, 16'd0, 16'd50, 16'd50, 4'b0010),
                           1'b0, res_t'('0)});
    table_rows.push_back('{insert_op(8'h33, 16'd10, 16'd10, 16'd5, 16'd5, 4'b0101),
                           1'b0, res_t'('0)});
    table_rows.push_back('{insert_op(8'h44, 16'd0, 16'd0, 16'd0, 16'd0, 4'b1111),
                           1'b0, res_t'('0)});
    table_rows.push_back('{insert_op(8'hFF, 16'd0, 16'd0, 16'd20, 16'd20, 4'b0000),
                           1'b0, res_t'('0)});
    table_rows.push_back('{find_op(16'h7FFF, 16'h7FFF, 1'b0), 1'b0, res_t'('0)});
    table_rows.push_back('{find_op(16'h8000, 16'h8000, 1'b0), 1'b0, res_t'('0)});
    table_rows.push_back('{find_op(16'd5, 16'd5, 1'b1), 1'b0, res_t'('0)});
    table_rows.push_back('{find_op(16'hFFFF, 16'hFFFF, 1'b1), 1'b0, res_t'('0)});
    table_rows.push_back('{handle_op(KIND_RAISE, 8'hFF), 1'b0, res_t'('0)});
    table_rows.push_back('{blank_op(KIND_SELECT), 1'b0, res_t'('0)});
    table_rows.push_back('{blank_op(KIND_HIDE), 1'b0, res_t'('0)});
    table_rows.push_back('{find_op(16'd0, 16'd0, 1'b0), 1'b0, res_t'('0)});
    table_rows.push_back('{handle_op(KIND_REMOVE, 8'hFF), 1'b0, res_t'('0)});
    table_rows.push_back('{handle_op(KIND_REMOVE, 8'h00), 1'b0, res_t'('0)});

    foreach (table_rows[i]) begin
      row = table_rows[i];
      send_op(row.op);
      if (row.typed) begin
        dummy = pending_results[$];
        if (dummy !== row.res) begin
          $error("table row %0d result: expected %h, actual %h", i, row.res, dummy);
          fail_count++;
        end
      end
    end

    // Fill the list to the top and check the full answer
    while (w_total < DEPTH)
      send_op(insert_op(8'($urandom_range(0, 15)), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom), 4'($urandom)));
    send_op(insert_op(8'h5A, '0, '0, '0, '0, '0));
    if (pending_results[$] !== res_t'({STATUS_FULL, 8'd0, 7'd64})) begin
      $error("full insert status: expected %0d, actual %0d",
             STATUS_FULL, pending_results[$].status);
      fail_count++;
    end

    // Pause until drained
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);

    // Long receiver hold-off while the sender keeps offering
    hold_off = 1'b1;
    fork
      begin
        repeat (600) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 12; i++) send_op(handle_op(KIND_REMOVE, 8'($urandom_range(0, 15))));
    join

    // Random traffic in bursts
    for (int n = 0; n < N_RANDOM; ) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && n < N_RANDOM; b++, n++) begin
        op = random_op();
        if (w_total > 48 && op.kind == KIND_INSERT && $urandom_range(0, 1))
          op.kind = KIND_REMOVE;
        send_op(op);
      end
      if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 150));
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[layered_window_list_engine_unit] OK");
    end else begin
      $display("[layered_window_list_engine_unit] ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/lwl_pkg.sv
hw/rtl/layered_window_list_engine_unit.sv
hw/rtl/lwl_checker.sv
dv/tb.sv
